[src/mqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_pkg
// Shared sizes, codes and types of the multilevel queue slot scheduler.
// ----------------------------------------------------------------------------
package mqs_pkg;

   localparam int NUM_LEVELS  = 8;
   localparam int QUEUE_DEPTH = 16;

   localparam int LEVEL_W     = $clog2(NUM_LEVELS);
   localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W      = $clog2(NUM_LEVELS + 1);
   localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int ID_W        = 8;
   localparam int IN_LEVEL_W  = 3;
   localparam int STATUS_W    = 2;
   localparam int TDATA_W     = 16;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_ADD = 1'b0,
      FUNC_GET = 1'b1
   } func_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   typedef struct packed {
      status_type            status;
      logic [IN_LEVEL_W-1:0] level;
      logic [ID_W-1:0]       id;
   } rsp_type;

endpackage

[src/multilevel_queue_slot_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_slot_scheduler
// Per-level FIFOs of process ids in one RAM, served weighted round robin.
// ----------------------------------------------------------------------------
// response: add and empty get respond in the cycle after the request is accepted,
//   a serving get first reads the id RAM, then registers the id as the response
// flow: no request is taken while a get waits on its id RAM read or a response stalls
// reset: synchronous, clears heads, counts and level, reloads the slots;
//   the id RAM needs no clearing pass
module multilevel_queue_slot_scheduler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [mqs_pkg::TDATA_W-1:0]  req_tdata,  // proc_id[7:0], level[10:8]
   input  logic                         req_tuser,  // func[0]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mqs_pkg::TDATA_W-1:0]  rsp_tdata,  // served_id[7:0], served_level[10:8]
   output logic [mqs_pkg::STATUS_W-1:0] rsp_tuser   // status[1:0]
);

   localparam int LW = mqs_pkg::LEVEL_W;
   localparam int NL = mqs_pkg::NUM_LEVELS;
   localparam int QD = mqs_pkg::QUEUE_DEPTH;

   mqs_pkg::state_type state_ff, state_in;
   logic [mqs_pkg::HEAD_W-1:0]  head_ff  [NL];
   logic [mqs_pkg::HEAD_W-1:0]  head_in  [NL];
   logic [mqs_pkg::COUNT_W-1:0] count_ff [NL];
   logic [mqs_pkg::COUNT_W-1:0] count_in [NL];
   logic [LW-1:0]               cur_ff, cur_in;
   logic [mqs_pkg::SLOT_W-1:0]  slots_ff, slots_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mqs_pkg::rsp_type            rsp_ff, rsp_in;
   logic [mqs_pkg::IN_LEVEL_W-1:0] pend_level_ff, pend_level_in;

   logic                        ram_we, ram_re;
   logic [mqs_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [mqs_pkg::ID_W-1:0]    ram_rdata;

   logic                        req_fire;
   logic [NL-1:0]               nonempty;
   logic                        advance;
   logic [LW-1:0]               start_level;
   logic                        found;
   logic                        found_first;
   logic [LW-1:0]               pick;
   logic [LW-1:0]               add_level;
   logic [mqs_pkg::HEAD_W-1:0]  add_tail;
   logic [mqs_pkg::HEAD_W-1:0]  pick_head_next;
   logic [LW+2:0]               pick_wide;

   assign req_tready = (state_ff == mqs_pkg::S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mqs_pkg::TDATA_W'({rsp_ff.level, rsp_ff.id});
   assign rsp_tuser  = rsp_ff.status;

   // level scan: rotating first-nonempty search from the start level
   always_comb begin
      logic [LW:0] idx;
      for (int i = 0; i < NL; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
      advance     = (slots_ff == '0) || !nonempty[cur_ff];
      start_level = cur_ff;
      if (advance) begin
         start_level = (cur_ff == LW'(NL - 1)) ? '0 : cur_ff + 1'b1;
      end
      found       = 1'b0;
      found_first = 1'b0;
      pick        = start_level;
      for (int i = 0; i < NL; i++) begin
         idx = {1'b0, start_level} + (LW + 1)'(i);
         if (idx >= (LW + 1)'(NL)) begin
            idx = idx - (LW + 1)'(NL);
         end
         if (!found && nonempty[idx[LW-1:0]]) begin
            found       = 1'b1;
            found_first = (i == 0);
            pick        = idx[LW-1:0];
         end
      end
      pick_wide = (LW + 3)'(pick);
      pick_head_next = (head_ff[pick] == mqs_pkg::HEAD_W'(QD - 1)) ? '0
                       : head_ff[pick] + 1'b1;
   end

   // add path: saturate the level, locate the tail
   always_comb begin
      logic [LW+3:0]                lvl_wide;
      logic [mqs_pkg::COUNT_W:0]    tail_sum;
      lvl_wide  = (LW + 4)'(req_tdata[mqs_pkg::ID_W +: mqs_pkg::IN_LEVEL_W]);
      add_level = (lvl_wide >= (LW + 4)'(NL)) ? LW'(NL - 1) : lvl_wide[LW-1:0];
      tail_sum  = (mqs_pkg::COUNT_W + 1)'(head_ff[add_level])
                  + (mqs_pkg::COUNT_W + 1)'(count_ff[add_level]);
      if (tail_sum >= (mqs_pkg::COUNT_W + 1)'(QD)) begin
         tail_sum = tail_sum - (mqs_pkg::COUNT_W + 1)'(QD);
      end
      add_tail = tail_sum[mqs_pkg::HEAD_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      slots_in      = slots_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_level_in = pend_level_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = mqs_pkg::ADDR_W'(add_level) * mqs_pkg::ADDR_W'(QD)
                      + mqs_pkg::ADDR_W'(add_tail);
      ram_raddr     = mqs_pkg::ADDR_W'(pick) * mqs_pkg::ADDR_W'(QD)
                      + mqs_pkg::ADDR_W'(head_ff[pick]);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mqs_pkg::S_IDLE: begin
            if (req_fire) begin
               if (mqs_pkg::func_type'(req_tuser) == mqs_pkg::FUNC_ADD) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: mqs_pkg::STATUS_OK, level: '0, id: '0};
                  if (count_ff[add_level] == mqs_pkg::COUNT_W'(QD)) begin
                     rsp_in.status = mqs_pkg::STATUS_FULL;
                  end else begin
                     ram_we              = 1'b1;
                     count_in[add_level] = count_ff[add_level] + 1'b1;
                  end
               end else if (found) begin
                  ram_re          = 1'b1;
                  head_in[pick]   = pick_head_next;
                  count_in[pick]  = count_ff[pick] - 1'b1;
                  cur_in          = pick;
                  // staying on the current level spends a slot, a move reloads
                  slots_in        = (found_first && !advance) ? slots_ff - 1'b1
                                    : mqs_pkg::SLOT_W'(NL - 1) - mqs_pkg::SLOT_W'(pick);
                  pend_level_in   = pick_wide[mqs_pkg::IN_LEVEL_W-1:0];
                  state_in        = mqs_pkg::S_READ;
               end else begin
                  cur_in       = start_level;
                  slots_in     = mqs_pkg::SLOT_W'(NL) - mqs_pkg::SLOT_W'(start_level);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: mqs_pkg::STATUS_EMPTY, level: '0, id: '0};
               end
            end
         end
         mqs_pkg::S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: mqs_pkg::STATUS_OK, level: pend_level_ff,
                             id: ram_rdata};
            state_in     = mqs_pkg::S_IDLE;
         end
         default: begin
            state_in = mqs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mqs_pkg::S_IDLE;
         cur_ff       <= '0;
         slots_ff     <= mqs_pkg::SLOT_W'(NL);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NL; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff        <= rsp_in;
      pend_level_ff <= pend_level_in;
   end

   mqs_ram #(
      .WIDTH (mqs_pkg::ID_W),
      .DEPTH (mqs_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_tdata[mqs_pkg::ID_W-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

[src/mqs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mqs_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 128,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/mqs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_checker
// Port-level checks of the multilevel queue slot scheduler.
// ----------------------------------------------------------------------------
module mqs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [mqs_pkg::TDATA_W-1:0]  rsp_tdata,
   input logic [mqs_pkg::STATUS_W-1:0] rsp_tuser
);

   // only the three status codes ever leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == mqs_pkg::STATUS_OK || rsp_tuser == mqs_pkg::STATUS_EMPTY
                      || rsp_tuser == mqs_pkg::STATUS_FULL))
      else $error("illegal status code");

   // a non-serving response carries no id and no level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != mqs_pkg::STATUS_OK) |-> (rsp_tdata == '0))
      else $error("non-serving response carries data");

   // no new request while a response is stuck
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken while response stalled");

   // an accepted request is followed by a valid response or by a drop of ready
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready || rsp_tvalid)
      else $error("request accepted without a response following");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind multilevel_queue_slot_scheduler mqs_checker u_mqs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
